FILE: hdl/ipta_pkg.sv
// Shared types, widths, codes and register defaults of the inverted page table allocator.
// No dependencies; the core, ipta_csr and ipta_hash import this package.
package ipta_pkg;

   // Table depth default and field widths
   localparam int FRAMES_DEF   = 1024;
   localparam int OP_W         = 2;
   localparam int PID_W        = 16;
   localparam int PAGE_W       = 8;
   localparam int FRAME_OUT_W  = 10;
   localparam int ADDR_OUT_W   = 22;
   localparam int FSIZE_W      = 13;
   localparam int TOTAL_W      = 11;
   localparam int ADMIN_W      = 10;
   localparam int LIMIT_W      = 11;
   // hash accumulator: pid + admin + page*(fsize+pid) + page*(page-1)/2 < 2^25
   localparam int ACC_W        = 25;
   localparam int PROD_W       = PAGE_W + PID_W + 1;
   localparam int TRI_W        = 2 * PAGE_W - 1;

   // Configuration port
   localparam int CSR_DATA_W   = 32;
   localparam int CSR_ADDR_W   = 4;

   // Register indexes
   localparam logic [1:0] REG_FRAME_SIZE   = 2'd0;
   localparam logic [1:0] REG_TOTAL_FRAMES = 2'd1;
   localparam logic [1:0] REG_ADMIN_FRAMES = 2'd2;
   localparam logic [1:0] REG_PROBE_LIMIT  = 2'd3;

   // Register reset values
   localparam logic [FSIZE_W-1:0] FRAME_SIZE_RST   = 13'd256;
   localparam logic [TOTAL_W-1:0] TOTAL_FRAMES_RST = 11'd1024;
   localparam logic [ADMIN_W-1:0] ADMIN_FRAMES_RST = 10'd16;
   localparam logic [LIMIT_W-1:0] PROBE_LIMIT_RST  = 11'd1024;

   // Operation codes
   localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
   localparam logic [OP_W-1:0] OP_LOOKUP  = 2'd1;
   localparam logic [OP_W-1:0] OP_RELEASE = 2'd2;

   typedef struct packed {
      logic [FSIZE_W-1:0] frame_size;
      logic [TOTAL_W-1:0] total_frames;
      logic [ADMIN_W-1:0] admin_frames;
      logic [LIMIT_W-1:0] probe_limit;
   } ipta_cfg_type;

   // Effective frame count: total_frames clamped to [1, frames]
   function automatic logic [TOTAL_W-1:0] eff_total(input logic [TOTAL_W-1:0] tot,
                                                   input int frames);
      logic [TOTAL_W-1:0] t;
      t = tot;
      if (tot == '0) begin
         t = TOTAL_W'(1);
      end else if (int'(tot) > frames) begin
         t = TOTAL_W'(frames);
      end
      return t;
   endfunction

endpackage

FILE: hdl/inverted_page_table_allocator_core.sv
// Top level of the inverted page table allocator: sequencer around the owner table.
// Depends on ipta_pkg, ipta_ram, ipta_csr and ipta_hash.
//
// Usage
//   Commands: a transaction is accepted at a rising edge with start high and busy low;
//   req_operation selects allocate, look up or release for req_pid / req_page.
//   Results: every command yields exactly one result transaction, shown on the rsp_ ports
//   for one cycle while rsp_valid is high. The receiver cannot stall, so nothing is held.
//   Configuration: APB-style port, registers frame_size, total_frames, admin_frames and
//   probe_limit at byte offsets 0, 4, 8 and 12; write only while busy is low.
// Sequence per operation
//   Look up: the 25-step restoring modulo in the hash unit, then one table read of the hashed frame.
//   Allocate: as look up, claiming the hashed frame when it is free; otherwise a probe of
//   up to min(probe_limit, total_frames) - admin_frames more frames, one read issued per cycle.
//   Release: all FRAMES entries, one read-modify-write per frame through the table RAM.
//   Unknown operation or release of pid 0: an all-zero result with no table access.
//   Commands are taken one at a time; busy stays high from acceptance to the result.
// Reset
//   Synchronous, active high. Registers return to their defaults and a clearing pass then
//   writes every frame free, one entry a cycle, with busy held high.
//   Configuration writes are taken during the pass.
module inverted_page_table_allocator_core #(
   parameter int FRAMES = ipta_pkg::FRAMES_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // command channel
   input  logic                                 start,
   output logic                                 busy,
   input  logic [ipta_pkg::OP_W-1:0]            req_operation,
   input  logic [ipta_pkg::PID_W-1:0]           req_pid,
   input  logic [ipta_pkg::PAGE_W-1:0]          req_page,
   // result channel
   output logic                                 rsp_valid,
   output logic                                 rsp_status,
   output logic [ipta_pkg::FRAME_OUT_W-1:0]     rsp_frame,
   output logic [ipta_pkg::PID_W-1:0]           rsp_owner_pid,
   output logic [ipta_pkg::ADDR_OUT_W-1:0]      rsp_start_address,
   // configuration port
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [ipta_pkg::CSR_ADDR_W-1:0]      paddr,
   input  logic [ipta_pkg::CSR_DATA_W-1:0]      pwdata,
   output logic [ipta_pkg::CSR_DATA_W-1:0]      prdata,
   output logic                                 pready
);
   import ipta_pkg::*;

   localparam int FRAME_W = $clog2(FRAMES);
   localparam int CNT_W   = $clog2(FRAMES + 1);
   localparam int APROD_W = (FRAME_W + FSIZE_W > ADDR_OUT_W) ? FRAME_W + FSIZE_W : ADDR_OUT_W;

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_HASH  = 3'd2;
   localparam logic [2:0] S_HCHK  = 3'd3;
   localparam logic [2:0] S_PROBE = 3'd4;
   localparam logic [2:0] S_REL   = 3'd5;
   localparam logic [2:0] S_EMIT  = 3'd6;

   ipta_cfg_type cfg;

   // sequencer state
   logic [2:0]         state_ff, state_in;
   logic [CNT_W-1:0]   scan_ff, scan_in;
   logic [FRAME_W-1:0] chk_ff, chk_in;
   logic               chk_vld_ff, chk_vld_in;
   logic [OP_W-1:0]    op_ff;
   logic [PID_W-1:0]   pid_ff;

   // pending result
   logic               res_status_ff, res_status_in;
   logic [FRAME_W-1:0] res_idx_ff, res_idx_in;
   logic [PID_W-1:0]   res_owner_ff, res_owner_in;
   logic               res_addr_en_ff, res_addr_en_in;

   // result registers
   logic                   rsp_valid_ff;
   logic                   rsp_status_ff;
   logic [FRAME_OUT_W-1:0] rsp_frame_ff;
   logic [PID_W-1:0]       rsp_owner_ff;
   logic [ADDR_OUT_W-1:0]  rsp_addr_ff;

   // table RAM ports
   logic               wr_en;
   logic [FRAME_W-1:0] wr_addr;
   logic [PID_W-1:0]   wr_data;
   logic [FRAME_W-1:0] rd_addr;
   logic [PID_W-1:0]   rd_data;

   // hash unit
   logic               hash_go;
   logic               hash_done;
   logic [TOTAL_W-1:0] hash_val;
   logic [FRAME_W-1:0] hash_idx;

   logic               accept;
   logic [TOTAL_W-1:0] tot;
   logic [LIMIT_W-1:0] lim;
   logic               issue_probe;
   logic               issue_rel;
   logic [APROD_W-1:0] addr_prod;

   ipta_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   ipta_hash #(
      .FRAMES (FRAMES)
   ) u_hash (
      .clock (clock),
      .reset (reset),
      .go    (hash_go),
      .pid   (req_pid),
      .page  (req_page),
      .cfg   (cfg),
      .done  (hash_done),
      .hash  (hash_val)
   );

   ipta_ram #(
      .WIDTH (PID_W),
      .DEPTH (FRAMES)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign busy     = (state_ff != S_IDLE);
   assign accept   = start & ~busy;
   assign hash_go  = accept & ((req_operation == OP_ALLOC) | (req_operation == OP_LOOKUP));
   assign hash_idx = FRAME_W'(hash_val);
   assign tot      = eff_total(cfg.total_frames, FRAMES);
   // probe bound: min(probe_limit, effective frame count)
   assign lim      = (cfg.probe_limit > LIMIT_W'(tot)) ? LIMIT_W'(tot) : cfg.probe_limit;
   assign issue_probe = (scan_ff < lim);
   assign issue_rel   = (scan_ff < CNT_W'(FRAMES));

   always_comb begin
      state_in       = state_ff;
      scan_in        = scan_ff;
      chk_in         = chk_ff;
      chk_vld_in     = chk_vld_ff;
      res_status_in  = res_status_ff;
      res_idx_in     = res_idx_ff;
      res_owner_in   = res_owner_ff;
      res_addr_en_in = res_addr_en_ff;
      wr_en          = 1'b0;
      wr_addr        = chk_ff;
      wr_data        = '0;
      rd_addr        = scan_ff[FRAME_W-1:0];

      case (state_ff)
         S_CLEAR: begin
            // sweep the table free after reset
            wr_en   = 1'b1;
            wr_addr = scan_ff[FRAME_W-1:0];
            if (scan_ff == CNT_W'(FRAMES - 1)) begin
               scan_in  = '0;
               state_in = S_IDLE;
            end else begin
               scan_in = scan_ff + 1'b1;
            end
         end

         S_IDLE: begin
            if (accept) begin
               res_status_in  = 1'b0;
               res_idx_in     = '0;
               res_owner_in   = '0;
               res_addr_en_in = 1'b0;
               scan_in        = '0;
               chk_vld_in     = 1'b0;
               if (hash_go) begin
                  state_in = S_HASH;
               end else if (req_operation == OP_RELEASE && req_pid != '0) begin
                  state_in = S_REL;
               end else begin
                  // unknown operation or release of pid 0: all-zero result
                  state_in = S_EMIT;
               end
            end
         end

         S_HASH: begin
            // fetch the owner of the hashed frame once the hash lands
            rd_addr = hash_idx;
            if (hash_done) begin
               state_in = S_HCHK;
            end
         end

         S_HCHK: begin
            if (op_ff == OP_LOOKUP) begin
               res_idx_in     = hash_idx;
               res_owner_in   = (hash_val < TOTAL_W'(cfg.admin_frames)) ? '0 : rd_data;
               res_addr_en_in = 1'b1;
               state_in       = S_EMIT;
            end else if (hash_val >= TOTAL_W'(cfg.admin_frames) && rd_data == '0) begin
               // hashed frame free: claim it
               wr_en          = 1'b1;
               wr_addr        = hash_idx;
               wr_data        = pid_ff;
               res_idx_in     = hash_idx;
               res_owner_in   = pid_ff;
               res_addr_en_in = 1'b1;
               state_in       = S_EMIT;
            end else if (LIMIT_W'(cfg.admin_frames) < lim) begin
               scan_in    = CNT_W'(cfg.admin_frames);
               chk_vld_in = 1'b0;
               state_in   = S_PROBE;
            end else begin
               res_status_in = 1'b1;
               state_in      = S_EMIT;
            end
         end

         S_PROBE: begin
            // one read issued per cycle, its data checked in the next
            if (chk_vld_ff && rd_data == '0) begin
               wr_en          = 1'b1;
               wr_data        = pid_ff;
               res_idx_in     = chk_ff;
               res_owner_in   = pid_ff;
               res_addr_en_in = 1'b1;
               state_in       = S_EMIT;
            end else if (issue_probe) begin
               scan_in    = scan_ff + 1'b1;
               chk_in     = scan_ff[FRAME_W-1:0];
               chk_vld_in = 1'b1;
            end else begin
               res_status_in = 1'b1;
               state_in      = S_EMIT;
            end
         end

         S_REL: begin
            // read each entry, write it free in the next cycle if the pid owns it
            if (chk_vld_ff && rd_data == pid_ff) begin
               wr_en = 1'b1;
            end
            if (issue_rel) begin
               scan_in    = scan_ff + 1'b1;
               chk_in     = scan_ff[FRAME_W-1:0];
               chk_vld_in = 1'b1;
            end else begin
               chk_vld_in = 1'b0;
               state_in   = S_EMIT;
            end
         end

         S_EMIT: begin
            state_in = S_IDLE;
         end

         default: state_in = S_IDLE;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         scan_ff      <= '0;
         chk_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         scan_ff      <= scan_in;
         chk_vld_ff   <= chk_vld_in;
         rsp_valid_ff <= (state_ff == S_EMIT);
      end
   end

   assign addr_prod = APROD_W'(res_idx_ff) * APROD_W'(cfg.frame_size);

   // payload: command fields, pending result and result registers
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff  <= req_operation;
         pid_ff <= req_pid;
      end
      chk_ff         <= chk_in;
      res_status_ff  <= res_status_in;
      res_idx_ff     <= res_idx_in;
      res_owner_ff   <= res_owner_in;
      res_addr_en_ff <= res_addr_en_in;
      if (state_ff == S_EMIT) begin
         rsp_status_ff <= res_status_ff;
         rsp_frame_ff  <= FRAME_OUT_W'(res_idx_ff);
         rsp_owner_ff  <= res_owner_ff;
         rsp_addr_ff   <= res_addr_en_ff ? addr_prod[ADDR_OUT_W-1:0] : '0;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_frame         = rsp_frame_ff;
   assign rsp_owner_pid     = rsp_owner_ff;
   assign rsp_start_address = rsp_addr_ff;

endmodule

FILE: hdl/ipta_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module ipta_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/ipta_csr.sv
// APB-style configuration registers of the allocator.
// Depends on ipta_pkg for widths, register indexes and reset values.
module ipta_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [ipta_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [ipta_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [ipta_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                pready,
   output ipta_pkg::ipta_cfg_type              cfg
);
   import ipta_pkg::*;

   ipta_cfg_type cfg_ff;
   logic         wr_strobe;
   logic [1:0]   reg_idx;

   assign pready    = 1'b1;
   assign wr_strobe = psel & penable & pwrite;
   assign reg_idx   = paddr[CSR_ADDR_W-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_size   <= FRAME_SIZE_RST;
         cfg_ff.total_frames <= TOTAL_FRAMES_RST;
         cfg_ff.admin_frames <= ADMIN_FRAMES_RST;
         cfg_ff.probe_limit  <= PROBE_LIMIT_RST;
      end else if (wr_strobe) begin
         case (reg_idx)
            REG_FRAME_SIZE:   cfg_ff.frame_size   <= pwdata[FSIZE_W-1:0];
            REG_TOTAL_FRAMES: cfg_ff.total_frames <= pwdata[TOTAL_W-1:0];
            REG_ADMIN_FRAMES: cfg_ff.admin_frames <= pwdata[ADMIN_W-1:0];
            REG_PROBE_LIMIT:  cfg_ff.probe_limit  <= pwdata[LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_FRAME_SIZE:   prdata = CSR_DATA_W'(cfg_ff.frame_size);
         REG_TOTAL_FRAMES: prdata = CSR_DATA_W'(cfg_ff.total_frames);
         REG_ADMIN_FRAMES: prdata = CSR_DATA_W'(cfg_ff.admin_frames);
         REG_PROBE_LIMIT:  prdata = CSR_DATA_W'(cfg_ff.probe_limit);
         default:          prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

FILE: hdl/ipta_hash.sv
// Hash unit: products, sum, a one-bit-per-cycle restoring modulo by the frame count, then plus one with wrap.
// Depends on ipta_pkg for widths, the config struct and eff_total.
module ipta_hash #(
   parameter int FRAMES = ipta_pkg::FRAMES_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               go,
   input  logic [ipta_pkg::PID_W-1:0]         pid,
   input  logic [ipta_pkg::PAGE_W-1:0]        page,
   input  ipta_pkg::ipta_cfg_type             cfg,
   output logic                               done,
   output logic [ipta_pkg::TOTAL_W-1:0]       hash
);
   import ipta_pkg::*;

   localparam int CNT_W = $clog2(ACC_W);

   localparam logic [1:0] H_IDLE = 2'd0;
   localparam logic [1:0] H_SUM  = 2'd1;
   localparam logic [1:0] H_DIV  = 2'd2;

   logic [1:0]         state_ff, state_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               done_ff, done_in;
   logic [PROD_W-1:0]  prod_ff;
   logic [TRI_W-1:0]   tri_ff;
   logic [PID_W:0]     base_ff;
   logic [ACC_W-1:0]   acc_ff, acc_in;
   logic [TOTAL_W-1:0] rem_ff, rem_in;
   logic [TOTAL_W-1:0] hash_ff, hash_in;

   logic [TOTAL_W-1:0] tot;
   logic [TOTAL_W:0]   shifted;
   logic [TOTAL_W:0]   hplus;
   logic [PID_W:0]     fs_pid;
   logic [PAGE_W-1:0]  page_dec;
   logic [2*PAGE_W-1:0] tri_full;

   assign tot      = eff_total(cfg.total_frames, FRAMES);
   assign fs_pid   = (PID_W+1)'(cfg.frame_size) + (PID_W+1)'(pid);
   assign page_dec = (page == '0) ? '0 : page - 1'b1;
   assign tri_full = page * page_dec;

   // one restoring step: shift in the next dividend bit, subtract if it fits
   assign shifted  = {rem_ff, acc_ff[ACC_W-1]};
   assign hplus    = (TOTAL_W+1)'(rem_in) + 1'b1;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      done_in  = 1'b0;
      acc_in   = acc_ff;
      rem_in   = rem_ff;
      hash_in  = hash_ff;
      if (shifted >= {1'b0, tot}) begin
         rem_in = TOTAL_W'(shifted - {1'b0, tot});
      end else begin
         rem_in = shifted[TOTAL_W-1:0];
      end
      case (state_ff)
         H_IDLE: begin
            if (go) begin
               state_in = H_SUM;
            end
         end
         H_SUM: begin
            acc_in   = ACC_W'(base_ff) + ACC_W'(prod_ff) + ACC_W'(tri_ff);
            cnt_in   = '0;
            state_in = H_DIV;
         end
         H_DIV: begin
            acc_in = {acc_ff[ACC_W-2:0], 1'b0};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(ACC_W - 1)) begin
               // wrap a hash that lands one past the end back to frame 0
               hash_in  = (hplus >= {1'b0, tot}) ? '0 : hplus[TOTAL_W-1:0];
               done_in  = 1'b1;
               state_in = H_IDLE;
            end
         end
         default: state_in = H_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= H_IDLE;
         done_ff  <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == H_IDLE && go) begin
         prod_ff <= page * fs_pid;
         tri_ff  <= tri_full[2*PAGE_W-1:1];
         base_ff <= (PID_W+1)'(pid) + (PID_W+1)'(cfg.admin_frames);
      end
      rem_ff  <= (state_ff == H_SUM) ? '0 : rem_in;
      acc_ff  <= acc_in;
      hash_ff <= hash_in;
   end

   assign done = done_ff;
   assign hash = hash_ff;

endmodule
